>>> hdl/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types, constants and helpers for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

   localparam int COORD_BITS     = 12;
   localparam int CSR_INDEX_BITS = 1;

   typedef logic [COORD_BITS-1:0]     coord_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic signed [8:0]         delta_type;
   typedef logic signed [COORD_BITS+1:0] wide_sum_type;

   localparam csr_index_type CSR_MAX_X = 1'b0;
   localparam csr_index_type CSR_MAX_Y = 1'b1;

   localparam coord_type RESET_MAX_X = COORD_BITS'(1019);
   localparam coord_type RESET_MAX_Y = COORD_BITS'(763);
   localparam coord_type RESET_CUR_X = COORD_BITS'(512);
   localparam coord_type RESET_CUR_Y = COORD_BITS'(384);

   localparam logic [2:0] BUTTON_LEFT   = 3'h1;
   localparam logic [2:0] BUTTON_RIGHT  = 3'h2;
   localparam logic [2:0] BUTTON_MIDDLE = 3'h4;
   localparam logic [2:0] BUTTON_MASK   = BUTTON_LEFT | BUTTON_RIGHT | BUTTON_MIDDLE;

   // position of the next byte inside a three-byte packet
   typedef enum logic [2:0] {
      PH_BUTTONS = 3'b001,
      PH_DX      = 3'b010,
      PH_DY      = 3'b100
   } phase_type;

   // add a signed delta and clamp to 0..limit
   function automatic coord_type clamp_axis(coord_type cur, delta_type delta, coord_type limit);
      wide_sum_type sum;
      wide_sum_type lim;
      coord_type    res;
      sum = wide_sum_type'({2'b00, cur}) + wide_sum_type'({{(COORD_BITS-7){delta[8]}}, delta});
      lim = wide_sum_type'({2'b00, limit});
      if (sum < 0) begin
         res = '0;
      end else if (sum > lim) begin
         res = limit;
      end else begin
         res = sum[COORD_BITS-1:0];
      end
      return res;
   endfunction

endpackage

>>> hdl/ps2mt_req_if.sv
// ----------------------------------------------------------------------------
// ps2mt_req_if
// Byte channel from the mouse receiver: valid/ready plus one raw byte.
// ----------------------------------------------------------------------------
interface ps2mt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hdl/ps2mt_rsp_if.sv
// ----------------------------------------------------------------------------
// ps2mt_rsp_if
// Result channel: cursor position, button state and packet-complete flag.
// ----------------------------------------------------------------------------
interface ps2mt_rsp_if;
   import ps2mt_pkg::*;

   logic       valid;
   logic       ready;
   coord_type  pos_x;
   coord_type  pos_y;
   logic [2:0] buttons;
   logic       packet_done;

   modport source (output valid, output pos_x, output pos_y, output buttons,
                   output packet_done, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input buttons,
                   input packet_done, output ready);
endinterface

>>> hdl/ps2mt_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_core
// Assembles PS/2 mouse bytes into three-byte packets and tracks the cursor.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries raw mouse bytes, one per transaction. The first byte of
//   a packet sets the buttons, the second is held as the x delta, and the
//   third (y delta, negated so y grows downward) moves the cursor, which is
//   clamped per axis to 0..max_x / 0..max_y.
//   rsp_chan returns one transaction per byte: current position, buttons and
//   packet_done, which is set on the byte that completed a packet.
//   csr_we/csr_index/csr_wdata write max_x (index 0) and max_y (index 1);
//   write only while no transaction is in flight.
// Timing:
//   an input register and a result register, with the add-and-clamp between
//   them: an accepted byte reaches rsp_chan via the result register. One
//   byte per cycle is sustained while rsp_chan.ready is high.
// Reset (synchronous): cursor at 512/384, buttons clear, limits 1019/763,
//   both channels empty.
// Stall: while rsp_chan.ready is low the result holds; if the input register
//   is empty, one more byte is taken into it, then req_chan.ready drops.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_core (
   input  logic                      clock,
   input  logic                      reset,
   ps2mt_req_if.sink                 req_chan,
   ps2mt_rsp_if.source               rsp_chan,
   input  logic                      csr_we,
   input  ps2mt_pkg::csr_index_type  csr_index,
   input  ps2mt_pkg::coord_type      csr_wdata
);
   import ps2mt_pkg::*;

   // configuration
   coord_type max_x_ff, max_y_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // packet state
   phase_type  phase_ff, phase_in;
   logic [7:0] held_dx_ff, held_dx_in;
   coord_type  cursor_x_ff, cursor_x_in;
   coord_type  cursor_y_ff, cursor_y_in;
   logic [2:0] button_bits_ff, button_bits_in;
   logic       done_in;

   // result register
   logic       out_valid_ff;
   coord_type  out_x_ff, out_y_ff;
   logic [2:0] out_buttons_ff;
   logic       out_done_ff;

   logic advance;
   logic in_take;
   delta_type dx, dy;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_take       = req_chan.valid && req_chan.ready;

   assign dx = delta_type'({held_dx_ff[7], held_dx_ff});
   assign dy = delta_type'(9'sd0 - delta_type'({in_byte_ff[7], in_byte_ff}));

   always_comb begin
      phase_in       = phase_ff;
      held_dx_in     = held_dx_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      button_bits_in = button_bits_ff;
      done_in        = 1'b0;
      case (phase_ff)
         PH_BUTTONS: begin
            button_bits_in = in_byte_ff[2:0] & BUTTON_MASK;
            phase_in       = PH_DX;
         end
         PH_DX: begin
            held_dx_in = in_byte_ff;
            phase_in   = PH_DY;
         end
         PH_DY: begin
            cursor_x_in = clamp_axis(cursor_x_ff, dx, max_x_ff);
            cursor_y_in = clamp_axis(cursor_y_ff, dy, max_y_ff);
            phase_in    = PH_BUTTONS;
            done_in     = 1'b1;
         end
         default: begin
            phase_in = PH_BUTTONS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= RESET_MAX_X;
         max_y_ff <= RESET_MAX_Y;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_X: max_x_ff <= csr_wdata;
            CSR_MAX_Y: max_y_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (in_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_BUTTONS;
         held_dx_ff     <= '0;
         cursor_x_ff    <= RESET_CUR_X;
         cursor_y_ff    <= RESET_CUR_Y;
         button_bits_ff <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         held_dx_ff     <= held_dx_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
         button_bits_ff <= button_bits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_x_ff       <= cursor_x_in;
         out_y_ff       <= cursor_y_in;
         out_buttons_ff <= button_bits_in;
         out_done_ff    <= done_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pos_x       = out_x_ff;
   assign rsp_chan.pos_y       = out_y_ff;
   assign rsp_chan.buttons     = out_buttons_ff;
   assign rsp_chan.packet_done = out_done_ff;

endmodule
